// ===== src/wfrm_pkg.sv =====
// ============================================================================
// wfrm_pkg: shared types and constants of the windowed frame rate meter
// Fixed result field widths and the fixed-point scale of the rate result.
// ============================================================================
`default_nettype none

package wfrm_pkg;

    // Result field widths.
    localparam int FPS_W    = 28;
    localparam int FRAMES_W = 32;
    localparam int VALID_W  = 6;

    // Result bus: fps_q8, frames_done, valid_in_window, padded to whole bytes.
    localparam int OUT_FIELDS_W = FPS_W + FRAMES_W + VALID_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // One million microseconds per second, scaled by 2^8 for the Q20.8 result.
    localparam logic [FPS_W-1:0] FPS_SCALE = FPS_W'(256000000);

    typedef logic [FPS_W-1:0]    fps_t;
    typedef logic [FRAMES_W-1:0] frames_t;
    typedef logic [VALID_W-1:0]  valid_cnt_t;

endpackage : wfrm_pkg

`default_nettype wire

// ===== src/windowed_frame_rate_meter.sv =====
// ============================================================================
// windowed_frame_rate_meter: moving-average frame rate over a window of frames
// Keeps the last WINDOW_DEPTH frame durations in a ring memory and returns the
// average frame rate in Q20.8 frames per second for every frame reported.
// ============================================================================
//
// Each input transaction carries the duration of one finished frame in
// microseconds; a zero duration marks an empty slot and is not counted. The
// block overwrites the oldest ring entry, updates a running sum and count of
// the non-zero entries, and returns one result transaction holding
// floor(256000000 * count / sum) (zero for an empty window), the wrapping
// frame total and the number of valid entries. One frame is processed at a
// time. The ring memory is read at the accepting edge; after it the block
// performs the read-modify-write of the window state, then the numerator
// multiply, then the restoring divider, which produces the NUM_W-bit
// quotient one bit per cycle, and then the load of the output register, where
// NUM_W = 28 + clog2(WINDOW_DEPTH + 1). The output load waits while a
// previous result is still held by the consumer. A new frame is accepted
// while a previous result still waits in the output register. The ring is
// a single-port synchronous memory; its reset contents are provided by one
// fill flag per entry, so no clearing pass follows reset.
//
`default_nettype none

module windowed_frame_rate_meter #(
    parameter int WINDOW_DEPTH = 60,
    parameter int TIME_BITS    = 24
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input stream. tdata fields from bit 0: frame_time_us[TIME_BITS-1:0].
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((TIME_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // Result stream. tdata fields from bit 0: fps_q8[27:0], frames_done[31:0],
    // valid_in_window[5:0], then zero padding.
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [wfrm_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

    import wfrm_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = TIME_BITS + CNT_W;
    localparam int NUM_W  = FPS_W + CNT_W;
    localparam int ITER_W = $clog2(NUM_W);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MULT,
        ST_DIV,
        ST_LOAD
    } state_t;

    state_t                  state_reg;
    logic [SLOT_W-1:0]       write_slot_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        count_reg;
    frames_t                 frame_total_reg;
    logic [WINDOW_DEPTH-1:0] filled_reg;
    logic [TIME_BITS-1:0]    time_reg;
    logic                    old_filled_reg;
    logic [TIME_BITS-1:0]    rd_data_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [SUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        quot_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic                    out_valid_reg;
    fps_t                    out_fps_reg;
    frames_t                 out_frames_reg;
    valid_cnt_t              out_count_reg;

    logic [TIME_BITS-1:0] ring_mem [WINDOW_DEPTH];

    logic                 in_accept;
    logic                 mem_we;
    logic [TIME_BITS-1:0] old_time;
    logic                 old_nz;
    logic                 new_nz;
    logic [SUM_W-1:0]     sum_next;
    logic [CNT_W-1:0]     count_next;
    logic [SLOT_W-1:0]    write_slot_next;
    logic [SUM_W:0]       trial;
    logic                 trial_ge;
    logic [SUM_W-1:0]     rem_next;
    logic                 out_free;
    logic                 load_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign mem_we        = (state_reg == ST_UPDATE);

    // A ring entry that was never written since reset reads as empty.
    assign old_time = old_filled_reg ? rd_data_reg : '0;
    assign old_nz   = (old_time != '0);
    assign new_nz   = (time_reg != '0);

    assign sum_next   = sum_reg - SUM_W'(old_time) + SUM_W'(time_reg);
    assign count_next = count_reg - CNT_W'(old_nz) + CNT_W'(new_nz);
    assign write_slot_next = (write_slot_reg == LAST_SLOT) ? '0 : write_slot_reg + 1'b1;

    // One restoring division step: the partial remainder stays below the sum.
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, sum_reg});
    assign rem_next = trial_ge ? SUM_W'(trial - {1'b0, sum_reg}) : SUM_W'(trial);

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign load_fire = (state_reg == ST_LOAD) && out_free;

    // Ring memory: one port, read on acceptance and written back in the next cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[write_slot_reg] <= time_reg;
        end
        if (in_accept)
        begin
            rd_data_reg <= ring_mem[write_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            write_slot_reg  <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            frame_total_reg <= '0;
            filled_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // A new result takes the output register in the same cycle that
            // the consumer takes the previous one.
            if (load_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        time_reg       <= s_axis_tdata[TIME_BITS-1:0];
                        old_filled_reg <= filled_reg[write_slot_reg];
                        state_reg      <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    sum_reg                    <= sum_next;
                    count_reg                  <= count_next;
                    filled_reg[write_slot_reg] <= 1'b1;
                    write_slot_reg             <= write_slot_next;
                    frame_total_reg            <= frame_total_reg + 1'b1;
                    state_reg                  <= ST_MULT;
                end
                ST_MULT:
                begin
                    num_reg   <= NUM_W'(count_reg) * NUM_W'(FPS_SCALE);
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    iter_reg  <= ITER_W'(NUM_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                    quot_reg <= {quot_reg[NUM_W-2:0], trial_ge};
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (load_fire)
                    begin
                        out_fps_reg    <= (sum_reg == '0) ? '0 : quot_reg[FPS_W-1:0];
                        out_frames_reg <= frame_total_reg;
                        out_count_reg  <= VALID_W'(count_reg);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_count_reg, out_frames_reg, out_fps_reg});

    // The window never counts more entries than it holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window count exceeds window depth");

    // Every counted entry is at least one microsecond.
    a_sum_ge_count: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg >= SUM_W'(count_reg))
        else $error("window sum below window count");

    // An empty sum and an empty count go together.
    a_sum_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg == '0) == (count_reg == '0))
        else $error("window sum and count disagree on emptiness");

    // The write pointer stays inside the ring.
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot outside the ring");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg && $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule : windowed_frame_rate_meter

`default_nettype wire

// ===== test/windowed_frame_rate_meter_tb.sv =====
// ============================================================================
// windowed_frame_rate_meter_tb: self-checking bench for the frame rate meter
// Streams frame durations into the meter and compares every rate result with
// a window ring kept alongside it, with random gaps on both stream sides.
// ============================================================================

module windowed_frame_rate_meter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wfrm_pkg::*;

    localparam int WINDOW_DEPTH    = 60;
    localparam int TIME_BITS       = 24;
    localparam int IN_DATA_W       = ((TIME_BITS + 7) / 8) * 8;
    localparam int PAD_W           = OUT_DATA_W - OUT_FIELDS_W;
    localparam int TOTAL_FRAMES    = 950;
    // The tail wait covers the time the divider takes for a frame.
    localparam int LATENCY_CYCLES  = 40;
    // Longest quiet stretch of a correct run: block cycles plus the longest
    // sender gap plus the longest receiver stall, taken many times over.
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int MAX_REPORTS     = 10;

    localparam logic [TIME_BITS-1:0] MAX_TIME_US = '1;

    typedef enum int {
        BURST_DRAIN,
        BURST_SLOWEST,
        BURST_FASTEST,
        BURST_TYPICAL,
        BURST_NOISE
    } burst_kind_t;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        valid_cnt_t       count;
        frames_t          frames;
        fps_t             fps;
    } rate_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    windowed_frame_rate_meter #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .TIME_BITS    (TIME_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // Fields from bit 0: frame_time_us[23:0].
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // Fields from bit 0: fps_q8[27:0], frames_done[31:0],
        // valid_in_window[5:0], zero padding.
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Window ring predictor: mirrors the meter's state and queues the result
    // that each accepted frame duration must produce.
    // ------------------------------------------------------------------------
    logic [TIME_BITS-1:0] ring_us [WINDOW_DEPTH];
    int unsigned          next_slot;
    logic [29:0]          sum_us;
    valid_cnt_t           live_count;
    frames_t              frames_ended;
    rate_result_t         pending_results [$];

    int unsigned frames_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned empty_window_results;
    int unsigned burst_count [burst_kind_t];
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;

    initial
    begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            ring_us[i] = '0;
        end
        next_slot    = 0;
        sum_us       = '0;
        live_count   = '0;
        frames_ended = '0;
    end

    // Q20.8 rate: 256000000 * count / sum, truncated; zero for an empty window.
    function automatic fps_t compute_fps_q8(valid_cnt_t count, logic [29:0] sum);
        longint unsigned numerator;
        if (count == 0 || sum == 0)
        begin
            return '0;
        end
        numerator = longint'(FPS_SCALE) * longint'(count);
        return fps_t'(numerator / longint'(sum));
    endfunction

    task automatic account_frame(input logic [TIME_BITS-1:0] time_us);
        rate_result_t         expected;
        logic [TIME_BITS-1:0] evicted;
        evicted = ring_us[next_slot];
        // A zero entry is an empty slot: it neither adds to the sum nor counts.
        if (evicted != '0)
        begin
            sum_us     = sum_us - 30'(evicted);
            live_count = live_count - 1'b1;
        end
        if (time_us != '0)
        begin
            sum_us     = sum_us + 30'(time_us);
            live_count = live_count + 1'b1;
        end
        ring_us[next_slot] = time_us;
        next_slot    = (next_slot == WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
        frames_ended = frames_ended + 1'b1;

        expected.pad    = '0;
        expected.count  = live_count;
        expected.frames = frames_ended;
        expected.fps    = compute_fps_q8(live_count, sum_us);
        pending_results.push_back(expected);
    endtask

    // Mostly back-to-back, some short pauses and now and then a long one.
    function automatic int pick_gap(bit enabled);
        int roll;
        if (!enabled)
        begin
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(80, 10);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one frame duration per transaction. tvalid stays high across
    // back-to-back transactions and only drops for a gap.
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic [TIME_BITS-1:0] time_us);
        int gap;
        gap = pick_gap(tx_gaps_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(time_us);
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        account_frame(time_us);
        frames_sent++;
    endtask

    // Receiver: ready toggles with random stalls, independent of tvalid.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(rx_stalls_on);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transaction is matched against the oldest
    // queued expectation, field by field, padding included.
    // ------------------------------------------------------------------------
    rate_result_t observed;
    assign observed = rate_result_t'(m_axis_tdata);

    always @(posedge clk)
    begin
        rate_result_t expected;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] unexpected result: fps_q8=%0d frames=%0d valid=%0d",
                             $realtime, observed.fps, observed.frames, observed.count);
                end
            end
            else
            begin
                expected = pending_results.pop_front();
                results_checked++;
                if (expected.count == 0)
                begin
                    empty_window_results++;
                end
                if (observed.fps !== expected.fps || observed.frames !== expected.frames
                    || observed.count !== expected.count || observed.pad !== expected.pad)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] frame %0d: expected fps_q8=%0d valid=%0d pad=%0h,",
                                 $realtime, expected.frames, expected.fps, expected.count,
                                 expected.pad);
                        $display("    got fps_q8=%0d frames=%0d valid=%0d pad=%0h",
                                 observed.fps, observed.frames, observed.count,
                                 observed.pad);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when neither side completes a transaction for
    // too long.
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_CYCLES)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                     WATCHDOG_CYCLES, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zeros into a freshly reset ring: the window stays empty, rate is zero.
    task automatic test_empty_window();
        send_frame('0);
        send_frame('0);
        send_frame('0);
    endtask

    // Shortest and longest frames, and a zero after real data.
    task automatic test_field_extremes();
        send_frame(TIME_BITS'(1));
        send_frame(MAX_TIME_US);
        send_frame('0);
        send_frame(TIME_BITS'(1));
        send_frame(TIME_BITS'(1));
        send_frame(MAX_TIME_US);
        send_frame(MAX_TIME_US - 1'b1);
        send_frame('0);
    endtask

    // Walking and alternating patterns so every input bit is seen both ways.
    task automatic test_bit_patterns();
        send_frame(TIME_BITS'(24'hAAAAAA));
        send_frame(TIME_BITS'(24'h555555));
        send_frame(TIME_BITS'(24'h800000));
        send_frame(TIME_BITS'(24'h000080));
        send_frame(TIME_BITS'(24'h00FF00));
        send_frame(TIME_BITS'(16667));
        send_frame(TIME_BITS'(33333));
    endtask

    // Random bursts of one kind each. Drain bursts push a full window of zeros
    // so the rate falls back to zero; slowest bursts feed the ring the largest
    // durations to climb toward the top of the running sum; fastest bursts
    // drive the rate to its maximum. Every burst wraps or advances the ring.
    task automatic test_random_bursts();
        burst_kind_t          kind;
        int unsigned          length;
        logic [TIME_BITS-1:0] time_us;
        while (frames_sent < TOTAL_FRAMES)
        begin
            kind = burst_kind_t'($urandom_range(BURST_NOISE, BURST_DRAIN));
            case (kind)
                BURST_DRAIN:   length = $urandom_range(75, WINDOW_DEPTH);
                BURST_SLOWEST: length = $urandom_range(70, 20);
                BURST_FASTEST: length = $urandom_range(70, 20);
                BURST_TYPICAL: length = $urandom_range(90, 10);
                default:       length = $urandom_range(40, 1);
            endcase
            burst_count[kind] = burst_count.exists(kind) ? burst_count[kind] + 1 : 1;
            // Roughly one burst in four runs with no idling on a side.
            tx_gaps_on   = ($urandom_range(3) != 0);
            rx_stalls_on = ($urandom_range(3) != 0);
            repeat (length)
            begin
                case (kind)
                    BURST_DRAIN:   time_us = '0;
                    BURST_SLOWEST: time_us = MAX_TIME_US - TIME_BITS'($urandom_range(3));
                    BURST_FASTEST: time_us = TIME_BITS'($urandom_range(3, 1));
                    BURST_TYPICAL: time_us = TIME_BITS'($urandom_range(100000, 4000));
                    default:
                    begin
                        time_us = TIME_BITS'($urandom());
                        if ($urandom_range(3) == 0)
                        begin
                            time_us = '0;
                        end
                    end
                endcase
                send_frame(time_us);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frames_sent          = 0;
        results_checked      = 0;
        mismatches           = 0;
        empty_window_results = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_window();
        test_field_extremes();
        test_bit_patterns();
        test_random_bursts();
        s_axis_tvalid <= 1'b0;

        // Drain outstanding results, then give the block time for strays.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * LATENCY_CYCLES) @(posedge clk);

        $display("Sent %0d frame durations, checked %0d rate results (%0d on an empty window).",
                 frames_sent, results_checked, empty_window_results);
        $display("Bursts: %0d drain, %0d slowest, %0d fastest, %0d typical, %0d noise.",
                 burst_count.exists(BURST_DRAIN)   ? burst_count[BURST_DRAIN]   : 0,
                 burst_count.exists(BURST_SLOWEST) ? burst_count[BURST_SLOWEST] : 0,
                 burst_count.exists(BURST_FASTEST) ? burst_count[BURST_FASTEST] : 0,
                 burst_count.exists(BURST_TYPICAL) ? burst_count[BURST_TYPICAL] : 0,
                 burst_count.exists(BURST_NOISE)   ? burst_count[BURST_NOISE]   : 0);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing.", mismatches,
                     pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
